### sv/mva_pkg.sv
package mva_pkg;

  localparam int unsigned DefaultMaxVoices = 8;
  localparam int unsigned CfgW             = 4;
  localparam int unsigned NoteW            = 7;
  localparam int unsigned StampW           = 32;
  localparam int unsigned MaskW            = 8;

  localparam logic [CfgW-1:0] ResetActiveVoices = 4'd8;

  typedef enum logic [1:0] {
    FuncNoteOn   = 2'd0,
    FuncNoteOff  = 2'd1,
    FuncKeyPress = 2'd2,
    FuncOther    = 2'd3
  } mva_func_e;

  typedef enum logic [1:0] {
    RouteOk       = 2'd0,
    RouteOffDrop  = 2'd1,
    RouteNoFree   = 2'd2,
    RouteNoActive = 2'd3
  } mva_route_e;

  typedef struct packed {
    mva_func_e                func;
    logic [7:0]               status_byte;
    logic [NoteW-1:0]         data_one;
    logic [6:0]               data_two;
    logic signed [StampW-1:0] stamp;
  } mva_item_t;

  typedef struct packed {
    logic [MaskW-1:0] dest_mask;
    mva_route_e       route_status;
    logic [7:0]       out_status_byte;
    logic [NoteW-1:0] out_data_one;
    logic [6:0]       out_data_two;
  } mva_result_t;

  // what the scan found so far
  typedef struct packed {
    logic match;
    logic rel;
    logic old;
  } mva_scan_flags_t;

endpackage

### sv/mva_voice_store.sv
module mva_voice_store #(
  parameter int unsigned MaxVoices = mva_pkg::DefaultMaxVoices,
  localparam int unsigned IdxW = (MaxVoices > 1) ? $clog2(MaxVoices) : 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             rd_en_i,
  input  logic [IdxW-1:0]                  rd_addr_i,
  output logic [mva_pkg::NoteW-1:0]        rd_note_o,
  output logic signed [mva_pkg::StampW-1:0] rd_stamp_o,
  output logic                             rd_released_o,
  input  logic                             wr_en_i,
  input  logic [IdxW-1:0]                  wr_addr_i,
  input  logic [mva_pkg::NoteW-1:0]        wr_note_i,
  input  logic signed [mva_pkg::StampW-1:0] wr_stamp_i,
  input  logic                             wr_released_i
);
  import mva_pkg::*;

  logic [NoteW-1:0]         note_mem  [MaxVoices];
  logic signed [StampW-1:0] stamp_mem [MaxVoices];
  logic                     rel_mem   [MaxVoices];

  logic [MaxVoices-1:0]     valid_q;
  logic                     hit_q;
  logic [NoteW-1:0]         note_rd_q;
  logic signed [StampW-1:0] stamp_rd_q;
  logic                     rel_rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      note_mem[wr_addr_i]  <= wr_note_i;
      stamp_mem[wr_addr_i] <= wr_stamp_i;
      rel_mem[wr_addr_i]   <= wr_released_i;
    end
    if (rd_en_i) begin
      note_rd_q  <= note_mem[rd_addr_i];
      stamp_rd_q <= stamp_mem[rd_addr_i];
      rel_rd_q   <= rel_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      hit_q   <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        hit_q <= valid_q[rd_addr_i];
      end
    end
  end

  // never-written voices read as free, note zero, stamp minus one
  assign rd_note_o     = hit_q ? note_rd_q : '0;
  assign rd_stamp_o    = hit_q ? stamp_rd_q : '1;
  assign rd_released_o = hit_q ? rel_rd_q : 1'b1;

endmodule

### sv/mva_scan_unit.sv
module mva_scan_unit #(
  parameter int unsigned MaxVoices = mva_pkg::DefaultMaxVoices,
  localparam int unsigned IdxW = (MaxVoices > 1) ? $clog2(MaxVoices) : 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              clear_i,
  input  logic signed [mva_pkg::StampW-1:0] clear_stamp_i,
  input  logic                              sample_i,
  input  logic [IdxW-1:0]                   idx_i,
  input  logic [mva_pkg::NoteW-1:0]         note_i,
  input  logic signed [mva_pkg::StampW-1:0] stamp_i,
  input  logic                              released_i,
  input  logic [mva_pkg::NoteW-1:0]         key_note_i,
  output mva_pkg::mva_scan_flags_t          flags_o,
  output logic [IdxW-1:0]                   match_idx_o,
  output logic [IdxW-1:0]                   rel_idx_o,
  output logic [IdxW-1:0]                   old_idx_o
);
  import mva_pkg::*;

  mva_scan_flags_t          flags_q, flags_d;
  logic [IdxW-1:0]          match_idx_q, match_idx_d;
  logic [IdxW-1:0]          rel_idx_q, rel_idx_d;
  logic [IdxW-1:0]          old_idx_q, old_idx_d;
  logic signed [StampW-1:0] rel_age_q, rel_age_d;
  logic signed [StampW-1:0] old_age_q, old_age_d;
  logic                     note_hit;
  logic                     rel_lt;
  logic                     old_lt;

  // shared compare unit: one voice per cycle
  assign note_hit = (note_i == key_note_i);
  assign rel_lt   = (stamp_i < rel_age_q);
  assign old_lt   = (stamp_i < old_age_q);

  always_comb begin
    flags_d     = flags_q;
    match_idx_d = match_idx_q;
    rel_idx_d   = rel_idx_q;
    old_idx_d   = old_idx_q;
    rel_age_d   = rel_age_q;
    old_age_d   = old_age_q;
    if (clear_i) begin
      flags_d   = '0;
      rel_age_d = clear_stamp_i;
      old_age_d = clear_stamp_i;
    end else if (sample_i) begin
      // lowest-numbered match wins
      if (note_hit && !flags_q.match) begin
        flags_d.match = 1'b1;
        match_idx_d   = idx_i;
      end
      // strict compare keeps the lowest number on equal age
      if (released_i && rel_lt) begin
        flags_d.rel = 1'b1;
        rel_idx_d   = idx_i;
        rel_age_d   = stamp_i;
      end
      if (old_lt) begin
        flags_d.old = 1'b1;
        old_idx_d   = idx_i;
        old_age_d   = stamp_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q     <= '0;
      match_idx_q <= '0;
      rel_idx_q   <= '0;
      old_idx_q   <= '0;
      rel_age_q   <= '0;
      old_age_q   <= '0;
    end else begin
      flags_q     <= flags_d;
      match_idx_q <= match_idx_d;
      rel_idx_q   <= rel_idx_d;
      old_idx_q   <= old_idx_d;
      rel_age_q   <= rel_age_d;
      old_age_q   <= old_age_d;
    end
  end

  assign flags_o     = flags_q;
  assign match_idx_o = match_idx_q;
  assign rel_idx_o   = rel_idx_q;
  assign old_idx_o   = old_idx_q;

endmodule

### sv/midi_voice_allocator.sv
// MIDI voice allocator. Each request carries one timestamped MIDI message and
// yields exactly one result: a voice mask, a route status and the forwarded
// bytes. Note on, note off and key pressure go to the lowest voice already on
// that note, else (not for note off) to the oldest released voice older than
// the message, else to the oldest voice older than it. Other messages go to
// every active voice. Voice state sits in a memory with one read port and one
// write port that one compare unit walks one voice per cycle; a note message
// scans the voice count (active_voices capped at MaxVoices), then passes a
// last-read state and a resolve state before the next accept, while other
// messages and a zero voice count go straight to resolve. The result waits in
// an output register, and the following request may be taken while it waits.
// active_voices may only be written while no request is in flight.
module midi_voice_allocator #(
  parameter int unsigned MaxVoices = mva_pkg::DefaultMaxVoices
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  mva_pkg::mva_item_t       in_item_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output mva_pkg::mva_result_t     out_result_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [mva_pkg::CfgW-1:0] cfg_data_i
);
  import mva_pkg::*;

  localparam int unsigned IdxW = (MaxVoices > 1) ? $clog2(MaxVoices) : 1;
  localparam int unsigned CntW = $clog2(MaxVoices + 1);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StLast,
    StResolve
  } state_e;

  state_e          state_q, state_d;
  logic [CfgW-1:0] active_q, active_d;
  mva_item_t       item_q, item_d;
  logic [IdxW-1:0] iss_q, iss_d;
  logic            rd_vld_q, rd_vld_d;
  logic [IdxW-1:0] rd_idx_q, rd_idx_d;
  logic            out_valid_q, out_valid_d;
  mva_result_t     out_q, out_d;

  logic [CntW-1:0]          n_voices;
  logic                     in_fire;
  logic                     rd_en;
  logic                     scan_clear;
  logic                     last_issue;
  logic                     out_free;
  logic [NoteW-1:0]         rd_note;
  logic signed [StampW-1:0] rd_stamp;
  logic                     rd_released;
  mva_scan_flags_t          flags;
  logic [IdxW-1:0]          match_idx;
  logic [IdxW-1:0]          rel_idx;
  logic [IdxW-1:0]          old_idx;
  logic                     tgt_ok;
  logic [IdxW-1:0]          tgt_idx;
  logic [MaskW-1:0]         res_mask;
  mva_route_e               res_route;
  logic                     wr_en;

  assign n_voices   = (32'(active_q) > MaxVoices) ? CntW'(MaxVoices) : CntW'(active_q);
  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign last_issue = (32'(iss_q) + 32'd1 == 32'(n_voices));
  assign out_free   = !out_valid_q || out_ready_i;

  // decide the routing from what the scan left behind
  always_comb begin
    tgt_ok    = 1'b0;
    tgt_idx   = '0;
    res_mask  = '0;
    res_route = RouteOk;
    if (n_voices == '0) begin
      res_route = RouteNoActive;
    end else if (item_q.func == FuncOther) begin
      for (int i = 0; i < MaskW; i++) begin
        res_mask[i] = (i < 32'(n_voices));
      end
    end else begin
      if (flags.match) begin
        tgt_ok  = 1'b1;
        tgt_idx = match_idx;
      end else if (item_q.func == FuncNoteOff) begin
        res_route = RouteOffDrop;
      end else if (flags.rel) begin
        tgt_ok  = 1'b1;
        tgt_idx = rel_idx;
      end else if (flags.old) begin
        tgt_ok  = 1'b1;
        tgt_idx = old_idx;
      end else begin
        res_route = RouteNoFree;
      end
      // voices past the mask width are routed but get no bit
      for (int i = 0; i < MaskW; i++) begin
        res_mask[i] = tgt_ok && (32'(tgt_idx) == i);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    active_d    = active_q;
    item_d      = item_q;
    iss_d       = iss_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    rd_en       = 1'b0;
    scan_clear  = 1'b0;
    wr_en       = 1'b0;

    if (cfg_valid_i) begin
      active_d = cfg_data_i;
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          item_d     = in_item_i;
          iss_d      = '0;
          scan_clear = 1'b1;
          if ((n_voices == '0) || (in_item_i.func == FuncOther)) begin
            state_d = StResolve;
          end else begin
            state_d = StScan;
          end
        end
      end
      StScan: begin
        rd_en = 1'b1;
        if (last_issue) begin
          state_d = StLast;
        end else begin
          iss_d = iss_q + 1'b1;
        end
      end
      StLast: begin
        // last voice read lands in the scan unit at this edge
        state_d = StResolve;
      end
      StResolve: begin
        if (out_free) begin
          wr_en                 = tgt_ok;
          out_valid_d           = 1'b1;
          out_d.dest_mask       = res_mask;
          out_d.route_status    = res_route;
          out_d.out_status_byte = item_q.status_byte;
          out_d.out_data_one    = item_q.data_one;
          out_d.out_data_two    = item_q.data_two;
          state_d               = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign rd_vld_d = rd_en;
  assign rd_idx_d = iss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      active_q    <= ResetActiveVoices;
      item_q      <= '0;
      iss_q       <= '0;
      rd_vld_q    <= 1'b0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      item_q      <= item_d;
      iss_q       <= iss_d;
      rd_vld_q    <= rd_vld_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  mva_voice_store #(
    .MaxVoices(MaxVoices)
  ) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rd_en_i      (rd_en),
    .rd_addr_i    (iss_q),
    .rd_note_o    (rd_note),
    .rd_stamp_o   (rd_stamp),
    .rd_released_o(rd_released),
    .wr_en_i      (wr_en),
    .wr_addr_i    (tgt_idx),
    .wr_note_i    (item_q.data_one),
    .wr_stamp_i   (item_q.stamp),
    .wr_released_i(item_q.func == FuncNoteOff)
  );

  mva_scan_unit #(
    .MaxVoices(MaxVoices)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      (scan_clear),
    .clear_stamp_i(in_item_i.stamp),
    .sample_i     (rd_vld_q),
    .idx_i        (rd_idx_q),
    .note_i       (rd_note),
    .stamp_i      (rd_stamp),
    .released_i   (rd_released),
    .key_note_i   (item_q.data_one),
    .flags_o      (flags),
    .match_idx_o  (match_idx),
    .rel_idx_o    (rel_idx),
    .old_idx_o    (old_idx)
  );

  assign out_valid_o  = out_valid_q;
  assign out_result_o = out_q;

  // scan never reads a voice beyond the active count
  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (32'(iss_q) < 32'(n_voices)))
    else $error("voice scan past active count");

  // a voice update always comes with a fresh result and a return to idle
  a_write_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> (out_valid_o && (state_q == StIdle) && !$past(out_valid_q && !out_ready_i)))
    else $error("voice update without result");

  // dropped or unplaced requests reach no voice
  a_drop_no_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_result_o.route_status != RouteOk)) |->
      (out_result_o.dest_mask == '0))
    else $error("dropped request with voice mask");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import mva_pkg::*;

  localparam int HoldCycles = 400;
  localparam int MaxShown   = 10;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_valid   = 1'b0;
  logic              in_ready;
  mva_item_t         in_item    = '0;
  logic              out_valid;
  logic              out_ready  = 1'b0;
  mva_result_t       out_result;
  logic              cfg_valid  = 1'b0;
  logic              cfg_ready;
  logic [CfgW-1:0]   cfg_data   = '0;

  // voice state as the allocator should see it
  logic [NoteW-1:0]         voice_note     [DefaultMaxVoices];
  logic signed [StampW-1:0] voice_stamp    [DefaultMaxVoices];
  logic                     voice_released [DefaultMaxVoices];
  logic [CfgW-1:0]          voice_count;

  mva_result_t      routes_due [$];
  logic [NoteW-1:0] note_pool [10];
  int               song_time = -1000;
  bit               calm = 1'b0;
  int               hold_asked = 0;
  int               hold_served = 0;
  int               hold_left = 0;
  int               stall_left = 0;
  int               mismatches = 0;
  int               messages_sent = 0;
  int               settings_used = 0;
  int               route_seen [4] = '{0, 0, 0, 0};

  midi_voice_allocator dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .in_item_i    (in_item),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .out_result_o (out_result),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_data_i   (cfg_data)
  );

  always #2 clk = ~clk;

  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // works out the routing of one message and advances the voice state
  function automatic mva_result_t route_message(mva_item_t m);
    mva_result_t              r;
    int                       n;
    int                       hit;
    int                       rel;
    int                       old;
    logic signed [StampW-1:0] rel_age;
    logic signed [StampW-1:0] old_age;
    r = '0;
    r.out_status_byte = m.status_byte;
    r.out_data_one    = m.data_one;
    r.out_data_two    = m.data_two;
    n = (voice_count > DefaultMaxVoices) ? DefaultMaxVoices : voice_count;
    hit = -1;
    if (n == 0) begin
      r.route_status = RouteNoActive;
    end else if (m.func == FuncOther) begin
      for (int v = 0; v < n; v++) r.dest_mask[v] = 1'b1;
    end else begin
      for (int v = 0; v < n; v++) begin
        if (hit < 0 && voice_note[v] == m.data_one) hit = v;
      end
      if (hit < 0 && m.func == FuncNoteOff) begin
        r.route_status = RouteOffDrop;
      end else if (hit < 0) begin
        rel = -1;
        old = -1;
        rel_age = m.stamp;
        old_age = m.stamp;
        for (int v = 0; v < n; v++) begin
          if (voice_released[v] && voice_stamp[v] < rel_age) begin
            rel_age = voice_stamp[v];
            rel = v;
          end
          if (voice_stamp[v] < old_age) begin
            old_age = voice_stamp[v];
            old = v;
          end
        end
        hit = (rel >= 0) ? rel : old;
        if (hit < 0) r.route_status = RouteNoFree;
      end
      if (hit >= 0) begin
        voice_note[hit]     = m.data_one;
        voice_stamp[hit]    = m.stamp;
        voice_released[hit] = (m.func == FuncNoteOff);
        r.dest_mask[hit]    = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic void flag_route(string why, mva_result_t want, mva_result_t got);
    mismatches++;
    if (mismatches <= MaxShown)
      $display("%0t %s: want mask %02h %s bytes %02h %02h %02h, got mask %02h %s bytes %02h %02h %02h",
               $time, why,
               want.dest_mask, want.route_status.name(), want.out_status_byte,
               want.out_data_one, want.out_data_two,
               got.dest_mask, got.route_status.name(), got.out_status_byte,
               got.out_data_one, got.out_data_two);
  endfunction

  // result side
  always @(posedge clk) begin
    mva_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (!$isunknown(out_result.route_status)) route_seen[int'(out_result.route_status)]++;
      if (routes_due.size() == 0) begin
        flag_route("result with nothing pending", '0, out_result);
      end else begin
        want = routes_due.pop_front();
        if (want.dest_mask !== out_result.dest_mask ||
            want.route_status !== out_result.route_status ||
            want.out_status_byte !== out_result.out_status_byte ||
            want.out_data_one !== out_result.out_data_one ||
            want.out_data_two !== out_result.out_data_two)
          flag_route("route mismatch", want, out_result);
      end
    end
  end

  // receiver: random stalls, plus a long hold-off when one is asked for
  always @(posedge clk) begin
    if (hold_served != hold_asked) begin
      hold_served = hold_asked;
      hold_left   = HoldCycles;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (calm || stall_left == 0) begin
      out_ready <= 1'b1;
      if (!calm && $urandom_range(0, 5) == 0) stall_left = pick_gap();
    end else begin
      out_ready <= 1'b0;
      stall_left--;
    end
  end

  task automatic send_request(mva_item_t m);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= m;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    routes_due.push_back(route_message(m));
    messages_sent++;
  endtask

  task automatic drain_routes();
    in_valid <= 1'b0;
    while (routes_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_voices(logic [CfgW-1:0] count);
    drain_routes();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= count;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid   <= 1'b0;
    voice_count = count;
    settings_used++;
  endtask

  function automatic mva_item_t make_msg(mva_func_e f, logic [NoteW-1:0] note, int stamp);
    mva_item_t m;
    m.func        = f;
    m.status_byte = 8'($urandom_range(0, 255));
    m.data_one    = note;
    m.data_two    = 7'($urandom_range(0, 127));
    m.stamp       = stamp;
    return m;
  endfunction

  // mostly a rising song clock over a small set of notes, with some stale,
  // tied, wild and extreme stamps mixed in
  function automatic mva_item_t random_message();
    mva_item_t m;
    int        pick;
    int        w;
    pick = $urandom_range(0, 99);
    w    = $urandom_range(0, 99);
    m.status_byte = 8'($urandom_range(0, 255));
    m.data_two    = 7'($urandom_range(0, 127));
    m.data_one    = note_pool[$urandom_range(0, 9)];
    if (w < 40)      m.func = FuncNoteOn;
    else if (w < 70) m.func = FuncNoteOff;
    else if (w < 85) m.func = FuncKeyPress;
    else             m.func = FuncOther;
    if (pick < 75) begin
      if ($urandom_range(0, 199) == 0) song_time += $urandom_range(1, 1 << 24);
      song_time += $urandom_range(1, 40);
      m.stamp = song_time;
    end else if (pick < 85) begin
      m.stamp = song_time - $urandom_range(0, 100);
    end else if (pick < 95) begin
      m.func     = mva_func_e'($urandom_range(0, 3));
      m.data_one = NoteW'($urandom_range(0, 127));
      m.stamp    = $urandom;
    end else begin
      case ($urandom_range(0, 3))
        0:       m.stamp = 32'h8000_0000;
        1:       m.stamp = 32'h7fff_ffff;
        2:       m.stamp = '0;
        default: m.stamp = '1;
      endcase
      m.data_one = $urandom_range(0, 1) ? 7'h7f : 7'h00;
    end
    return m;
  endfunction

  task automatic test_directed_routing();
    mva_item_t m;
    write_voices(ResetActiveVoices);
    // note 0 hits the fresh voice 0
    send_request(make_msg(FuncNoteOn, 0, 100));
    send_request(make_msg(FuncNoteOn, 60, 200));
    send_request(make_msg(FuncKeyPress, 60, 210));
    send_request(make_msg(FuncNoteOff, 60, 220));
    send_request(make_msg(FuncNoteOff, 99, 230));
    m = make_msg(FuncOther, 7'h7f, 240);
    m.status_byte = 8'hff;
    m.data_two    = 7'h7f;
    send_request(m);
    // nothing is older than the most negative stamp
    m = make_msg(FuncNoteOn, 7'h7f, 32'h8000_0000);
    m.status_byte = 8'h00;
    m.data_two    = 7'h00;
    send_request(m);
    send_request(make_msg(FuncNoteOn, 7'h7f, 32'h7fff_ffff));
    send_request(make_msg(FuncKeyPress, 5, 0));
  endtask

  task automatic test_release_and_steal();
    calm = 1'b1;
    // equal stamps on the first half give an age tie when stealing
    for (int k = 0; k < DefaultMaxVoices; k++)
      send_request(make_msg(FuncNoteOn, NoteW'(20 + k), (k < 4) ? 5000 : 5000 + k));
    send_request(make_msg(FuncNoteOn, 40, 6000));
    send_request(make_msg(FuncNoteOff, 22, 6010));
    send_request(make_msg(FuncNoteOn, 41, 6020));
    send_request(make_msg(FuncKeyPress, 41, 6030));
    calm = 1'b0;
  endtask

  task automatic test_voice_count_limits();
    write_voices('0);
    send_request(make_msg(FuncNoteOn, 50, 6100));
    send_request(make_msg(FuncNoteOff, 50, 6110));
    send_request(make_msg(FuncOther, 50, 6120));
    // above MaxVoices the allocator clamps the voice count
    write_voices('1);
    send_request(make_msg(FuncOther, 51, 6130));
    send_request(make_msg(FuncNoteOn, 52, 6140));
    write_voices(4'd1);
    send_request(make_msg(FuncNoteOn, 70, 7000));
    send_request(make_msg(FuncNoteOn, 71, 7010));
  endtask

  task automatic test_random_traffic();
    logic [CfgW-1:0] plan [9] = '{4'd8, 4'd3, 4'd15, 4'd1, 4'd0, 4'd6, 4'd8, 4'd2, 4'd12};
    foreach (plan[p]) begin
      write_voices(plan[p]);
      calm = (p % 3 == 2);
      foreach (note_pool[k]) note_pool[k] = NoteW'($urandom_range(0, 127));
      repeat ((plan[p] == 0) ? 30 : 200) send_request(random_message());
    end
    calm = 1'b0;
  endtask

  task automatic test_output_backpressure();
    write_voices(ResetActiveVoices);
    hold_asked++;
    repeat (60) send_request(random_message());
  endtask

  initial begin
    for (int v = 0; v < DefaultMaxVoices; v++) begin
      voice_note[v]     = '0;
      voice_stamp[v]    = '1;
      voice_released[v] = 1'b1;
    end
    voice_count = ResetActiveVoices;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_routing();
    test_release_and_steal();
    test_voice_count_limits();
    test_random_traffic();
    test_output_backpressure();
    drain_routes();
    repeat (20) @(posedge clk);
    $display("covered %0d messages over %0d voice-count settings incl. 0, 1, 8 and 15",
             messages_sent, settings_used);
    $display("routed %0d, note-offs dropped %0d, unplaced %0d, silenced %0d, mismatches %0d",
             route_seen[0], route_seen[1], route_seen[2], route_seen[3], mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
